[hw/rtl/irbed_pkg.sv]
// Shared constants, types and the saturating timer helper of the IR blink edge detector.
package irbed_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int WINDOW_LEN    = 50;
  localparam int MEAN_RING_LEN = 50;
  localparam int SETTLE_TICKS  = 100;
  localparam int SETTLE_W      = 7;
  localparam int IDX_W         = 6;
  localparam int SUM_W         = 16;
  localparam int MEAN_W        = 10;
  localparam int SLOPE_W       = 11;
  localparam int TIMER_W       = 12;

  localparam int RECIP_W    = 17;
  localparam int MEAN_SHIFT = 22;
  localparam logic [RECIP_W-1:0] MEAN_RECIP = 17'd83887;

  localparam logic [TIMER_W-1:0] TIMER_MAX = 12'hFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int THR_W   = 5;
  localparam int LIMIT_W = 10;

  localparam logic [THR_W-1:0]   DELTA_THRESHOLD_RST     = 5'd12;
  localparam logic [TIMER_W-1:0] REST_TICKS_RST          = 12'd20;
  localparam logic [TIMER_W-1:0] REBASELINE_TICKS_RST    = 12'd100;
  localparam logic [TIMER_W-1:0] BLINK_TIMEOUT_TICKS_RST = 12'd1000;
  localparam logic [LIMIT_W-1:0] SLOPE_RISE_LIMIT_RST    = 10'd4;
  localparam logic [LIMIT_W-1:0] SLOPE_FALL_LIMIT_RST    = 10'd3;

  typedef enum logic [1:0] {
    PH_SETTLING,
    PH_REST,
    PH_EDGE,
    PH_BLINK_END
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELTA_THRESHOLD     = 3'd0,
    REG_REST_TICKS          = 3'd1,
    REG_REBASELINE_TICKS    = 3'd2,
    REG_BLINK_TIMEOUT_TICKS = 3'd3,
    REG_SLOPE_RISE_LIMIT    = 3'd4,
    REG_SLOPE_FALL_LIMIT    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
    return (t == TIMER_MAX) ? t : t + 1'b1;
  endfunction

endpackage

[hw/rtl/irbed_front.sv]
// Front end: accepts sample pairs, forms the reading and keeps the window sum.
module irbed_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [irbed_pkg::SAMPLE_W-1:0] sample_lit,
  input  logic [irbed_pkg::SAMPLE_W-1:0] sample_dark,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [irbed_pkg::SUM_W-1:0]   q_push_sum
);

  logic [irbed_pkg::SAMPLE_W-1:0] ring_mem [irbed_pkg::WINDOW_LEN];

  logic [irbed_pkg::IDX_W-1:0]    idx_r;
  logic [irbed_pkg::IDX_W-1:0]    idx_nxt;
  logic                           wrapped_r;
  logic [irbed_pkg::SAMPLE_W-1:0] old_r;
  logic [irbed_pkg::SUM_W-1:0]    sum_r;
  logic [irbed_pkg::SUM_W-1:0]    sum_nxt;
  logic [irbed_pkg::SAMPLE_W-1:0] reading;
  logic [irbed_pkg::SAMPLE_W-1:0] old_val;
  logic                           idx_last;
  logic                           accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign reading = (sample_lit > sample_dark) ? sample_lit - sample_dark
                                              : sample_dark - sample_lit;

  assign idx_last = (idx_r == irbed_pkg::IDX_W'(irbed_pkg::WINDOW_LEN - 1));
  assign idx_nxt  = idx_last ? '0 : idx_r + 1'b1;

  // Entries are written in order, so all are valid once the index has wrapped.
  assign old_val = wrapped_r ? old_r : '0;
  assign sum_nxt = sum_r - irbed_pkg::SUM_W'(old_val) + irbed_pkg::SUM_W'(reading);

  assign q_push     = accept;
  assign q_push_sum = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      wrapped_r <= 1'b0;
      sum_r     <= '0;
    end else if (accept) begin
      idx_r     <= idx_nxt;
      wrapped_r <= wrapped_r || idx_last;
      sum_r     <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring_mem[idx_r] <= reading;
      old_r           <= ring_mem[idx_nxt];
    end
  end

endmodule

[hw/rtl/irbed_queue.sv]
// Short queue of window sums between the front end and the back end.
module irbed_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [irbed_pkg::SUM_W-1:0] push_data,
  output logic                        full,
  input  logic                        pop,
  output logic [irbed_pkg::SUM_W-1:0] pop_data,
  output logic                        empty
);

  logic [irbed_pkg::SUM_W-1:0]  entry_r [irbed_pkg::QUEUE_DEPTH];
  logic [irbed_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [irbed_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [irbed_pkg::QCNT_W-1:0] count_r;

  assign full     = (count_r == irbed_pkg::QCNT_W'(irbed_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/irbed_back.sv]
// Back end: mean, ring of means, slope, blink state machine and result register.
module irbed_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irbed_pkg::cfg_wr_t            cfg,
  input  logic                          q_empty,
  input  logic [irbed_pkg::SUM_W-1:0]   q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          click_active,
  output logic                          press_event,
  output logic                          release_event,
  output logic [irbed_pkg::MEAN_W-1:0]  window_mean,
  output logic signed [irbed_pkg::SLOPE_W-1:0] slope
);

  localparam int PROD_W = irbed_pkg::SUM_W + irbed_pkg::RECIP_W;
  localparam int HYST_W = 15;
  localparam int CMP_W  = irbed_pkg::MEAN_W + 1;

  // Configuration registers
  logic [irbed_pkg::THR_W-1:0]   delta_threshold_r;
  logic [irbed_pkg::TIMER_W-1:0] rest_ticks_r;
  logic [irbed_pkg::TIMER_W-1:0] rebaseline_ticks_r;
  logic [irbed_pkg::TIMER_W-1:0] blink_timeout_ticks_r;
  logic [irbed_pkg::LIMIT_W-1:0] slope_rise_limit_r;
  logic [irbed_pkg::LIMIT_W-1:0] slope_fall_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_threshold_r     <= irbed_pkg::DELTA_THRESHOLD_RST;
      rest_ticks_r          <= irbed_pkg::REST_TICKS_RST;
      rebaseline_ticks_r    <= irbed_pkg::REBASELINE_TICKS_RST;
      blink_timeout_ticks_r <= irbed_pkg::BLINK_TIMEOUT_TICKS_RST;
      slope_rise_limit_r    <= irbed_pkg::SLOPE_RISE_LIMIT_RST;
      slope_fall_limit_r    <= irbed_pkg::SLOPE_FALL_LIMIT_RST;
    end else if (cfg.we) begin
      unique case (cfg.index)
        irbed_pkg::REG_DELTA_THRESHOLD: begin
          delta_threshold_r <= cfg.data[irbed_pkg::THR_W-1:0];
        end
        irbed_pkg::REG_REST_TICKS: begin
          rest_ticks_r <= cfg.data[irbed_pkg::TIMER_W-1:0];
        end
        irbed_pkg::REG_REBASELINE_TICKS: begin
          rebaseline_ticks_r <= cfg.data[irbed_pkg::TIMER_W-1:0];
        end
        irbed_pkg::REG_BLINK_TIMEOUT_TICKS: begin
          blink_timeout_ticks_r <= cfg.data[irbed_pkg::TIMER_W-1:0];
        end
        irbed_pkg::REG_SLOPE_RISE_LIMIT: begin
          slope_rise_limit_r <= cfg.data[irbed_pkg::LIMIT_W-1:0];
        end
        irbed_pkg::REG_SLOPE_FALL_LIMIT: begin
          slope_fall_limit_r <= cfg.data[irbed_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline control
  logic v1_r;
  logic out_valid_r;
  logic s1_load;
  logic s2_load;

  assign s2_load   = v1_r && (!out_valid_r || out_ready);
  assign s1_load   = !q_empty && (!v1_r || s2_load);
  assign q_pop     = s1_load;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        v1_r <= 1'b1;
      end else if (s2_load) begin
        v1_r <= 1'b0;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage 1: division of the window sum by the window length via reciprocal
  logic [PROD_W-1:0]              prod;
  logic [irbed_pkg::MEAN_W-1:0]   mean1_r;

  assign prod = PROD_W'(q_data) * PROD_W'(irbed_pkg::MEAN_RECIP);

  always_ff @(posedge clk) begin
    if (s1_load) begin
      mean1_r <= prod[irbed_pkg::MEAN_SHIFT +: irbed_pkg::MEAN_W];
    end
  end

  // Stage 2: ring of means and slope
  logic [irbed_pkg::MEAN_W-1:0] mean_mem [irbed_pkg::MEAN_RING_LEN];
  logic [irbed_pkg::IDX_W-1:0]  midx_r;
  logic [irbed_pkg::IDX_W-1:0]  midx_nxt;
  logic [irbed_pkg::IDX_W-1:0]  pre_addr;
  logic                         midx_last;
  logic                         mwrapped_r;
  logic [irbed_pkg::MEAN_W-1:0] oldest_r;
  logic [irbed_pkg::MEAN_W-1:0] oldest;
  logic signed [irbed_pkg::SLOPE_W-1:0] slope_now;
  logic signed [irbed_pkg::SLOPE_W:0]   fall_sum;
  logic edge_hit;

  assign midx_last = (midx_r == irbed_pkg::IDX_W'(irbed_pkg::MEAN_RING_LEN - 1));
  assign midx_nxt  = midx_last ? '0 : midx_r + 1'b1;
  assign pre_addr  = (midx_nxt == irbed_pkg::IDX_W'(irbed_pkg::MEAN_RING_LEN - 1))
                     ? '0 : midx_nxt + 1'b1;

  // The entry after the current one was written unless the ring is still filling.
  assign oldest = (mwrapped_r || midx_last) ? oldest_r : '0;

  assign slope_now = $signed({1'b0, mean1_r}) - $signed({1'b0, oldest});
  assign fall_sum  = $signed({slope_now[irbed_pkg::SLOPE_W-1], slope_now})
                   + $signed({2'b00, slope_fall_limit_r});
  assign edge_hit  = (slope_now > $signed({1'b0, slope_rise_limit_r}))
                   || fall_sum[irbed_pkg::SLOPE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      midx_r     <= '0;
      mwrapped_r <= 1'b0;
    end else if (s2_load) begin
      midx_r     <= midx_nxt;
      mwrapped_r <= mwrapped_r || midx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      mean_mem[midx_r] <= mean1_r;
      oldest_r         <= mean_mem[pre_addr];
    end
  end

  // Blink state machine
  irbed_pkg::phase_t phase_r;
  irbed_pkg::phase_t phase_nxt;
  logic [irbed_pkg::SETTLE_W-1:0] settle_r;
  logic [irbed_pkg::SETTLE_W-1:0] settle_nxt;
  logic [irbed_pkg::MEAN_W-1:0]   baseline_r;
  logic [irbed_pkg::MEAN_W-1:0]   baseline_nxt;
  logic [irbed_pkg::TIMER_W-1:0]  rest_r;
  logic [irbed_pkg::TIMER_W-1:0]  rest_nxt;
  logic [irbed_pkg::TIMER_W-1:0]  rebase_r;
  logic [irbed_pkg::TIMER_W-1:0]  rebase_nxt;
  logic [irbed_pkg::TIMER_W-1:0]  blink_r;
  logic [irbed_pkg::TIMER_W-1:0]  blink_nxt;
  logic                           movement_r;
  logic                           movement_nxt;
  logic [irbed_pkg::TIMER_W-1:0]  rest_inc;
  logic [irbed_pkg::TIMER_W-1:0]  rebase_inc;
  logic [irbed_pkg::TIMER_W-1:0]  blink_inc;
  logic                           press_cond;
  logic                           hyst_cond;
  logic [HYST_W-1:0]              hyst_lhs;
  logic [HYST_W-1:0]              hyst_rhs;
  logic                           press_evt;
  logic                           release_evt;

  assign rest_inc   = irbed_pkg::sat_inc(rest_r);
  assign rebase_inc = irbed_pkg::sat_inc(rebase_r);
  assign blink_inc  = irbed_pkg::sat_inc(blink_r);

  assign press_cond = CMP_W'(mean1_r) > (CMP_W'(baseline_r) + CMP_W'(delta_threshold_r));
  assign hyst_lhs   = HYST_W'(mean1_r) * HYST_W'(10);
  assign hyst_rhs   = HYST_W'(baseline_r) * HYST_W'(10)
                    + HYST_W'(delta_threshold_r) * HYST_W'(7);
  assign hyst_cond  = hyst_lhs < hyst_rhs;

  always_comb begin
    phase_nxt    = phase_r;
    settle_nxt   = settle_r;
    baseline_nxt = baseline_r;
    rest_nxt     = rest_r;
    rebase_nxt   = rebase_r;
    blink_nxt    = blink_r;
    movement_nxt = movement_r;
    press_evt    = 1'b0;
    release_evt  = 1'b0;
    unique case (phase_r)
      irbed_pkg::PH_SETTLING: begin
        if (settle_r <= irbed_pkg::SETTLE_W'(irbed_pkg::SETTLE_TICKS)) begin
          settle_nxt = settle_r + 1'b1;
        end else begin
          rest_nxt  = '0;
          phase_nxt = irbed_pkg::PH_REST;
        end
      end
      irbed_pkg::PH_REST: begin
        movement_nxt = 1'b0;
        rest_nxt     = rest_inc;
        if (rest_inc > rest_ticks_r) begin
          phase_nxt    = irbed_pkg::PH_EDGE;
          baseline_nxt = mean1_r;
          rebase_nxt   = '0;
        end
      end
      irbed_pkg::PH_EDGE: begin
        rebase_nxt = rebase_inc;
        if (edge_hit) begin
          if (press_cond) begin
            press_evt    = 1'b1;
            movement_nxt = 1'b1;
            blink_nxt    = '0;
            phase_nxt    = irbed_pkg::PH_BLINK_END;
          end
          rebase_nxt = '0;
        end else if (rebase_inc > rebaseline_ticks_r) begin
          rest_nxt  = '0;
          phase_nxt = irbed_pkg::PH_REST;
        end
      end
      irbed_pkg::PH_BLINK_END: begin
        blink_nxt   = blink_inc;
        release_evt = hyst_cond || ((blink_inc > blink_timeout_ticks_r) && edge_hit);
        if (release_evt) begin
          movement_nxt = 1'b0;
          rest_nxt     = '0;
          phase_nxt    = irbed_pkg::PH_REST;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= irbed_pkg::PH_SETTLING;
      settle_r   <= '0;
      baseline_r <= '0;
      rest_r     <= '0;
      rebase_r   <= '0;
      blink_r    <= '0;
      movement_r <= 1'b0;
    end else if (s2_load) begin
      phase_r    <= phase_nxt;
      settle_r   <= settle_nxt;
      baseline_r <= baseline_nxt;
      rest_r     <= rest_nxt;
      rebase_r   <= rebase_nxt;
      blink_r    <= blink_nxt;
      movement_r <= movement_nxt;
    end
  end

  // Result register
  logic                                click_r;
  logic                                press_r;
  logic                                release_r;
  logic [irbed_pkg::MEAN_W-1:0]        mean_out_r;
  logic signed [irbed_pkg::SLOPE_W-1:0] slope_out_r;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      click_r     <= movement_nxt;
      press_r     <= press_evt;
      release_r   <= release_evt;
      mean_out_r  <= mean1_r;
      slope_out_r <= slope_now;
    end
  end

  assign click_active  = click_r;
  assign press_event   = press_r;
  assign release_event = release_r;
  assign window_mean   = mean_out_r;
  assign slope         = slope_out_r;

endmodule

[hw/rtl/ir_blink_edge_detector_unit.sv]
// Top level of the IR blink edge detector.
//
// One input item is one millisecond tick carrying a lit and a dark IR sample.
// Every accepted item yields exactly one result item: the click state, press
// and release pulses, the 50-sample moving mean and the slope of the means.
// The configuration port writes one register per cycle; the user must write it only
// while the block is idle, which the block itself does not enforce.
//
// Accepted items pass the queue, the mean stage and the result register in turn.
// Throughput: one item per cycle while the receiver does not stall the output.
//
// Reset clears the control state: both rings read as zero until filled, the
// detector starts settling and the registers take their default values.
// When the receiver stalls, the result register holds its item, up to one item
// waits in the mean stage and four window sums wait in the queue; in_tready falls
// only once that queue is full.
module ir_blink_edge_detector_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // sample_lit [9:0], sample_dark [19:10], zeros
  input  logic [irbed_pkg::TDATA_IN_W-1:0]     in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // click_active, press_event, release_event, window_mean [12:3], slope [23:13]
  output logic [irbed_pkg::TDATA_OUT_W-1:0]    out_tdata,
  input  logic                                 cfg_we,
  input  logic [irbed_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irbed_pkg::CFG_DATA_W-1:0]     cfg_data
);

  irbed_pkg::cfg_wr_t cfg;

  logic                                 q_full;
  logic                                 q_empty;
  logic                                 q_push;
  logic                                 q_pop;
  logic [irbed_pkg::SUM_W-1:0]          q_push_sum;
  logic [irbed_pkg::SUM_W-1:0]          q_pop_sum;
  logic                                 click_active;
  logic                                 press_event;
  logic                                 release_event;
  logic [irbed_pkg::MEAN_W-1:0]         window_mean;
  logic signed [irbed_pkg::SLOPE_W-1:0] slope;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  irbed_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .sample_lit  (in_tdata[9:0]),
    .sample_dark (in_tdata[19:10]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_sum  (q_push_sum)
  );

  irbed_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_sum),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_sum),
    .empty     (q_empty)
  );

  irbed_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_data        (q_pop_sum),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .click_active  (click_active),
    .press_event   (press_event),
    .release_event (release_event),
    .window_mean   (window_mean),
    .slope         (slope)
  );

  assign out_tdata = {slope, window_mean, release_event, press_event, click_active};

endmodule

[tb/irbed_click_checker.sv]
// Checker of the IR blink edge detector: predicts every result item and compares it.
`timescale 1ns / 100ps
module irbed_click_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // sample_lit [9:0], sample_dark [19:10], zeros
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // click_active, press_event, release_event,
                                  // window_mean [12:3], slope [23:13]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          mismatch_count,
  output int          pending_ticks
);

  typedef struct packed {
    logic signed [10:0] slope;
    logic [9:0]         mean;
    logic               release_ev;
    logic               press_ev;
    logic               click;
  } click_result_t;

  click_result_t expected_q[$];
  int            result_no;

  logic [4:0]  thr;
  logic [11:0] rest_lim;
  logic [11:0] rebase_lim;
  logic [11:0] timeout_lim;
  logic [9:0]  rise_lim;
  logic [9:0]  fall_lim;

  logic [9:0]        diff_hist [irbed_pkg::WINDOW_LEN];
  logic [15:0]       diff_sum;
  int                diff_pos;
  logic [9:0]        mean_hist [irbed_pkg::MEAN_RING_LEN];
  int                mean_pos;
  irbed_pkg::phase_t det_phase;
  logic [6:0]        settle_cnt;
  logic [9:0]        base;
  logic [11:0]       rest_t;
  logic [11:0]       rebase_t;
  logic [11:0]       blink_t;
  logic              click;

  function automatic logic [11:0] bump(input logic [11:0] t);
    return (t == 12'hFFF) ? t : t + 12'd1;
  endfunction

  task automatic predict_tick(input logic [9:0] lit, input logic [9:0] dark,
                              output click_result_t res);
    logic [9:0] diff;
    logic [9:0] mean_now;
    logic [9:0] mean_old;
    int         slope_i;
    logic       edge_hit;
    logic       pressed;
    logic       released;
    diff     = (lit > dark) ? lit - dark : dark - lit;
    pressed  = 1'b0;
    released = 1'b0;

    diff_sum = diff_sum - diff_hist[diff_pos] + diff;
    diff_hist[diff_pos] = diff;
    diff_pos = (diff_pos == irbed_pkg::WINDOW_LEN - 1) ? 0 : diff_pos + 1;
    mean_now = 10'(diff_sum / irbed_pkg::WINDOW_LEN);

    mean_hist[mean_pos] = mean_now;
    mean_pos = (mean_pos == irbed_pkg::MEAN_RING_LEN - 1) ? 0 : mean_pos + 1;
    mean_old = mean_hist[mean_pos];
    slope_i  = int'(mean_now) - int'(mean_old);
    edge_hit = (slope_i > int'(rise_lim)) || (slope_i < -int'(fall_lim));

    case (det_phase)
      irbed_pkg::PH_SETTLING: begin
        if (int'(settle_cnt) <= irbed_pkg::SETTLE_TICKS) begin
          settle_cnt = settle_cnt + 7'd1;
        end else begin
          rest_t    = '0;
          det_phase = irbed_pkg::PH_REST;
        end
      end
      irbed_pkg::PH_REST: begin
        click  = 1'b0;
        rest_t = bump(rest_t);
        if (rest_t > rest_lim) begin
          det_phase = irbed_pkg::PH_EDGE;
          base      = mean_now;
          rebase_t  = '0;
        end
      end
      irbed_pkg::PH_EDGE: begin
        rebase_t = bump(rebase_t);
        if (edge_hit) begin
          if (int'(mean_now) > int'(base) + int'(thr)) begin
            pressed   = 1'b1;
            click     = 1'b1;
            blink_t   = '0;
            det_phase = irbed_pkg::PH_BLINK_END;
          end
          rebase_t = '0;
        end else if (rebase_t > rebase_lim) begin
          rest_t    = '0;
          det_phase = irbed_pkg::PH_REST;
        end
      end
      default: begin
        blink_t = bump(blink_t);
        if (10 * int'(mean_now) < 10 * int'(base) + 7 * int'(thr)) released = 1'b1;
        if (blink_t > timeout_lim && edge_hit) released = 1'b1;
        if (released) begin
          click     = 1'b0;
          rest_t    = '0;
          det_phase = irbed_pkg::PH_REST;
        end
      end
    endcase

    res.click      = click;
    res.press_ev   = pressed;
    res.release_ev = released;
    res.mean       = mean_now;
    res.slope      = 11'(slope_i);
  endtask

  always @(posedge clk) begin : watch
    click_result_t exp_r;
    click_result_t got_r;
    click_result_t new_r;
    if (!rst_n) begin
      thr         = 5'd12;
      rest_lim    = 12'd20;
      rebase_lim  = 12'd100;
      timeout_lim = 12'd1000;
      rise_lim    = 10'd4;
      fall_lim    = 10'd3;
      foreach (diff_hist[i]) diff_hist[i] = '0;
      foreach (mean_hist[i]) mean_hist[i] = '0;
      diff_sum   = '0;
      diff_pos   = 0;
      mean_pos   = 0;
      det_phase  = irbed_pkg::PH_SETTLING;
      settle_cnt = '0;
      base       = '0;
      rest_t     = '0;
      rebase_t   = '0;
      blink_t    = '0;
      click      = 1'b0;
      expected_q.delete();
      result_no      = 0;
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          irbed_pkg::REG_DELTA_THRESHOLD:     thr         = cfg_data[4:0];
          irbed_pkg::REG_REST_TICKS:          rest_lim    = cfg_data;
          irbed_pkg::REG_REBASELINE_TICKS:    rebase_lim  = cfg_data;
          irbed_pkg::REG_BLINK_TIMEOUT_TICKS: timeout_lim = cfg_data;
          irbed_pkg::REG_SLOPE_RISE_LIMIT:    rise_lim    = cfg_data[9:0];
          irbed_pkg::REG_SLOPE_FALL_LIMIT:    fall_lim    = cfg_data[9:0];
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        got_r = out_tdata;
        if (expected_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result item %0d arrived with nothing expected: click %0b press %0b",
                     $realtime, result_no, got_r.click, got_r.press_ev,
                     " release %0b mean %0d slope %0d",
                     got_r.release_ev, got_r.mean, got_r.slope);
          end
          mismatch_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r.click != exp_r.click || got_r.press_ev != exp_r.press_ev ||
              got_r.release_ev != exp_r.release_ev || got_r.mean != exp_r.mean ||
              got_r.slope != exp_r.slope) begin
            if (mismatch_count < 10) begin
              $display("%0t: result item %0d expected click %0b press %0b release %0b",
                       $realtime, result_no, exp_r.click, exp_r.press_ev, exp_r.release_ev,
                       " mean %0d slope %0d, got click %0b press %0b release %0b",
                       exp_r.mean, exp_r.slope, got_r.click, got_r.press_ev,
                       got_r.release_ev, " mean %0d slope %0d", got_r.mean, got_r.slope);
            end
            mismatch_count++;
          end
        end
        result_no++;
      end

      if (in_tvalid && in_tready) begin
        predict_tick(in_tdata[9:0], in_tdata[19:10], new_r);
        expected_q.push_back(new_r);
      end
    end
    pending_ticks = expected_q.size();
  end

endmodule

[tb/ir_blink_edge_detector_unit_tb.sv]
// Testbench top of the IR blink edge detector: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module ir_blink_edge_detector_unit_tb;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LEVEL_NOISE  = 2;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_CHOKED
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  int       mismatch_count;
  int       pending_ticks;
  int       quiet_cycles;
  int       burst_left;
  rx_mode_t ready_mode = RX_OPEN;
  int       mode_left;
  int       ready_tick;

  always #2 clk = ~clk;

  ir_blink_edge_detector_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  irbed_click_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_ticks  (pending_ticks)
  );

  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (mode_left == 0) begin
      ready_mode <= rx_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
      default:   out_tready <= (ready_tick % 8 >= 6);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("ir_blink_edge_detector_unit verification failed");
    $finish;
  end

  task automatic send_tick(input logic [9:0] lit, input logic [9:0] dark);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, dark, lit};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_level(input int level, input int count);
    int         r;
    logic [9:0] lo;
    for (int i = 0; i < count; i++) begin
      r = level + int'($urandom_range(0, 2 * LEVEL_NOISE)) - LEVEL_NOISE;
      if (r < 0) r = 0;
      if (r > 1023) r = 1023;
      lo = 10'($urandom_range(0, 1023 - r));
      if ($urandom_range(0, 1) == 1) begin
        send_tick(10'(lo + r), lo);
      end else begin
        send_tick(lo, 10'(lo + r));
      end
    end
  endtask

  task automatic send_blink(input int quiet, input int amp, input int pre, input int hold,
                            input int tail);
    send_level(quiet, pre);
    send_level(quiet + amp, hold);
    send_level(quiet, tail);
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) send_tick(10'($urandom), 10'($urandom));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_ticks == 0);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Narrow registers get random bits above their width, which must be dropped.
  task automatic set_detector(input int thr, input int rest, input int rebase,
                              input int timeout, input int rise, input int fall);
    write_reg(irbed_pkg::REG_DELTA_THRESHOLD, 12'(($urandom_range(0, 127) << 5) | thr));
    write_reg(irbed_pkg::REG_REST_TICKS, 12'(rest));
    write_reg(irbed_pkg::REG_REBASELINE_TICKS, 12'(rebase));
    write_reg(irbed_pkg::REG_BLINK_TIMEOUT_TICKS, 12'(timeout));
    write_reg(irbed_pkg::REG_SLOPE_RISE_LIMIT, 12'(($urandom_range(0, 3) << 10) | rise));
    write_reg(irbed_pkg::REG_SLOPE_FALL_LIMIT, 12'(($urandom_range(0, 3) << 10) | fall));
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int quiet;
    int rest;
    int pick;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of both samples while the detector is still settling.
    send_tick(10'd0, 10'd0);
    send_tick(10'h3FF, 10'd0);
    send_tick(10'd0, 10'h3FF);
    send_tick(10'h3FF, 10'h3FF);
    send_tick(10'h3FF, 10'h3FE);
    send_tick(10'd1, 10'd0);
    send_tick(10'd0, 10'd1);
    send_tick(10'd512, 10'd511);
    send_tick(10'd511, 10'd512);
    send_tick(10'h2AA, 10'h155);
    send_tick(10'h155, 10'h2AA);

    // Default registers: settle, capture a baseline and blink twice.
    send_level(30, 100);
    send_blink(30, 150, 25, 30, 50);
    drain_results();
    send_blink(30, $urandom_range(40, 300), 10, $urandom_range(25, 40), 45);
    send_noise(10);

    // Lowest limits: every non-zero slope is an edge and the timeout is immediate.
    drain_results();
    set_detector(25, 0, 0, 0, 0, 0);
    send_level(10, 10);
    send_blink(10, 200, 5, 25, 40);
    send_noise(5);

    // Highest limits: no edge can occur and the rest timer never expires.
    drain_results();
    write_reg(REG_SPARE_LO, 12'($urandom));
    write_reg(REG_SPARE_HI, 12'($urandom));
    set_detector(20, 4095, 0, 4095, 1023, 1023);
    send_level(0, 15);

    // Random registers, then one blink or a burst of noise.
    drain_results();
    rest = $urandom_range(0, 10);
    set_detector($urandom_range(0, 25), rest, $urandom_range(0, 150),
                 ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 250),
                 $urandom_range(0, 30), $urandom_range(0, 30));
    quiet = $urandom_range(0, 150);
    send_level(quiet, rest + 5);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      send_blink(quiet, $urandom_range(20, 300), 5, $urandom_range(20, 30), 30);
    end else if (pick < 7) begin
      send_blink(quiet, $urandom_range(5, 300), 5, $urandom_range(3, 20), 30);
    end else begin
      send_noise($urandom_range(8, 15));
      send_level(quiet, 20);
    end

    drain_results();
    if (mismatch_count == 0 && pending_ticks == 0) begin
      $display("ir_blink_edge_detector_unit verification clean");
    end else begin
      $display("ir_blink_edge_detector_unit verification failed");
    end
    $finish;
  end

endmodule
